[src/rti_pkg.sv]
package rti_pkg;

	localparam int COORD_W  = 16;
	localparam int EDGE_W   = COORD_W + 1;
	localparam int PV_W     = 2 * COORD_W + 2;
	localparam int QV_W     = 2 * COORD_W + 3;
	localparam int DOT_W    = 3 * COORD_W + 6;
	localparam int MAG_W    = DOT_W - 1;
	localparam int FRAC_W   = 16;
	localparam int QUO_W    = 32;
	localparam int DIV_STEPS = QUO_W;
	localparam int LANES    = 3;
	localparam int MIN_DET_W = 20;
	localparam int MIN_T_W  = 16;
	localparam int CFG_IDX_W = 2;
	localparam int BARY_W   = 17;

	localparam logic [1:0] REQ_LOAD_A = 2'd0;
	localparam logic [1:0] REQ_LOAD_B = 2'd1;
	localparam logic [1:0] REQ_LOAD_C = 2'd2;
	localparam logic [1:0] REQ_RAY    = 2'd3;

	localparam logic [CFG_IDX_W-1:0] CFG_MIN_ABS_DET = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MIN_T       = 2'd1;

	localparam int LANE_T = 0;
	localparam int LANE_U = 1;
	localparam int LANE_V = 2;

	typedef logic signed [COORD_W-1:0] coord_t;
	typedef coord_t vec3_t [3];
	typedef logic [MAG_W-1:0] mag_t;
	typedef logic [QUO_W-1:0] quo_t;

	typedef enum logic [2:0] {
		OUT_HIT       = 3'd0,
		OUT_PARALLEL  = 3'd1,
		OUT_U_OUTSIDE = 3'd2,
		OUT_V_OUTSIDE = 3'd3,
		OUT_SHORT     = 3'd4
	} outcome_t;

	typedef struct packed {
		outcome_t code;
		logic     tsat;
		mag_t     den;
		mag_t     num_t;
		mag_t     num_u;
		mag_t     num_v;
	} div_in_t;

	typedef struct packed {
		outcome_t code;
		logic     tsat;
		quo_t     q_t;
		quo_t     q_u;
		quo_t     q_v;
	} div_out_t;

endpackage

[src/rti_geom.sv]
module rti_geom (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              adv,
	input  logic                              ray_valid,
	input  rti_pkg::vec3_t                    va,
	input  rti_pkg::vec3_t                    vb,
	input  rti_pkg::vec3_t                    vc,
	input  rti_pkg::vec3_t                    org,
	input  rti_pkg::vec3_t                    dir,
	input  logic [rti_pkg::MIN_DET_W-1:0]     min_abs_det,
	output logic                              out_valid,
	output rti_pkg::div_in_t                  dout
);
	import rti_pkg::*;

	logic valid_s1, valid_s2, valid_s3, valid_s4, valid_s5, valid_s6, valid_s7;

	logic signed [EDGE_W-1:0]  e1_s1 [3], e2_s1 [3], tv_s1 [3];
	coord_t                    dir_s1 [3];

	logic signed [PV_W-2:0]    pm_s2 [6];
	logic signed [QV_W-2:0]    qm_s2 [6];
	logic signed [EDGE_W-1:0]  e1_s2 [3], e2_s2 [3], tv_s2 [3];
	coord_t                    dir_s2 [3];

	logic signed [PV_W-1:0]    pv_s3 [3];
	logic signed [QV_W-1:0]    qv_s3 [3];
	logic signed [EDGE_W-1:0]  e1_s3 [3], e2_s3 [3], tv_s3 [3];
	coord_t                    dir_s3 [3];

	logic signed [DOT_W-1:0]   dp_s4 [3], up_s4 [3], vp_s4 [3], tp_s4 [3];

	logic signed [DOT_W-1:0]   det_s5, un_s5, vn_s5, tn_s5;

	mag_t                      detm_s6;
	logic signed [DOT_W-1:0]   un_s6, vn_s6, tn_s6;

	div_in_t                   div_s7;

	logic signed [DOT_W:0]     uv_sum;
	logic signed [DOT_W-1:0]   det_pos;
	logic                      det_zero, det_small, u_out, v_out, t_pos, t_big;
	outcome_t                  code_c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
			valid_s7 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= ray_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
			valid_s6 <= valid_s5;
			valid_s7 <= valid_s6;
		end
	end

	always_comb begin
		det_pos   = {1'b0, detm_s6};
		det_zero  = (detm_s6 == '0);
		det_small = (detm_s6 < MAG_W'(min_abs_det));
		u_out     = (un_s6 < 0) || (un_s6 > det_pos);
		uv_sum    = (DOT_W+1)'(un_s6) + (DOT_W+1)'(vn_s6);
		v_out     = (vn_s6 < 0) || (uv_sum > (DOT_W+1)'(det_pos));
		t_pos     = (tn_s6 > 0);
		// whole part of t/det would exceed 16 bits
		t_big     = ({{FRAC_W{1'b0}}, tn_s6[MAG_W-1:0]} >= {detm_s6, {FRAC_W{1'b0}}});
		if (det_zero || det_small)
			code_c = OUT_PARALLEL;
		else if (u_out)
			code_c = OUT_U_OUTSIDE;
		else if (v_out)
			code_c = OUT_V_OUTSIDE;
		else
			code_c = OUT_HIT;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				e1_s1[i]  <= EDGE_W'(vb[i]) - EDGE_W'(va[i]);
				e2_s1[i]  <= EDGE_W'(vc[i]) - EDGE_W'(va[i]);
				tv_s1[i]  <= EDGE_W'(org[i]) - EDGE_W'(va[i]);
				dir_s1[i] <= dir[i];
			end

			pm_s2[0] <= dir_s1[1] * e2_s1[2];
			pm_s2[1] <= dir_s1[2] * e2_s1[1];
			pm_s2[2] <= dir_s1[2] * e2_s1[0];
			pm_s2[3] <= dir_s1[0] * e2_s1[2];
			pm_s2[4] <= dir_s1[0] * e2_s1[1];
			pm_s2[5] <= dir_s1[1] * e2_s1[0];
			qm_s2[0] <= tv_s1[1] * e1_s1[2];
			qm_s2[1] <= tv_s1[2] * e1_s1[1];
			qm_s2[2] <= tv_s1[2] * e1_s1[0];
			qm_s2[3] <= tv_s1[0] * e1_s1[2];
			qm_s2[4] <= tv_s1[0] * e1_s1[1];
			qm_s2[5] <= tv_s1[1] * e1_s1[0];
			e1_s2  <= e1_s1;
			e2_s2  <= e2_s1;
			tv_s2  <= tv_s1;
			dir_s2 <= dir_s1;

			for (int i = 0; i < 3; i++) begin
				pv_s3[i] <= PV_W'(pm_s2[2*i]) - PV_W'(pm_s2[2*i+1]);
				qv_s3[i] <= QV_W'(qm_s2[2*i]) - QV_W'(qm_s2[2*i+1]);
			end
			e1_s3  <= e1_s2;
			e2_s3  <= e2_s2;
			tv_s3  <= tv_s2;
			dir_s3 <= dir_s2;

			for (int i = 0; i < 3; i++) begin
				dp_s4[i] <= DOT_W'(e1_s3[i] * pv_s3[i]);
				up_s4[i] <= DOT_W'(tv_s3[i] * pv_s3[i]);
				vp_s4[i] <= DOT_W'(dir_s3[i] * qv_s3[i]);
				tp_s4[i] <= DOT_W'(e2_s3[i] * qv_s3[i]);
			end

			det_s5 <= dp_s4[0] + dp_s4[1] + dp_s4[2];
			un_s5  <= up_s4[0] + up_s4[1] + up_s4[2];
			vn_s5  <= vp_s4[0] + vp_s4[1] + vp_s4[2];
			tn_s5  <= tp_s4[0] + tp_s4[1] + tp_s4[2];

			// flip all numerators with a negative determinant
			if (det_s5 < 0) begin
				detm_s6 <= MAG_W'(-det_s5);
				un_s6   <= -un_s5;
				vn_s6   <= -vn_s5;
				tn_s6   <= -tn_s5;
			end else begin
				detm_s6 <= MAG_W'(det_s5);
				un_s6   <= un_s5;
				vn_s6   <= vn_s5;
				tn_s6   <= tn_s5;
			end

			div_s7.code  <= code_c;
			div_s7.tsat  <= t_pos && t_big;
			div_s7.den   <= detm_s6;
			div_s7.num_t <= t_pos ? tn_s6[MAG_W-1:0] : '0;
			div_s7.num_u <= un_s6[MAG_W-1:0];
			div_s7.num_v <= vn_s6[MAG_W-1:0];
		end
	end

	assign out_valid = valid_s7;
	assign dout      = div_s7;

endmodule

[src/rti_div.sv]
module rti_div (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              adv,
	input  logic              in_valid,
	input  rti_pkg::div_in_t  din,
	output logic              out_valid,
	output rti_pkg::div_out_t dout
);
	import rti_pkg::*;

	logic     valid_s [1:DIV_STEPS];
	outcome_t code_s  [1:DIV_STEPS];
	logic     tsat_s  [1:DIV_STEPS];
	mag_t     den_s   [1:DIV_STEPS];
	mag_t     rem_s   [1:DIV_STEPS][LANES];
	quo_t     nb_s    [1:DIV_STEPS][LANES];
	quo_t     q_s     [1:DIV_STEPS][LANES];

	mag_t     cur_den [DIV_STEPS];
	mag_t     cur_rem [DIV_STEPS][LANES];
	quo_t     cur_nb  [DIV_STEPS][LANES];
	quo_t     cur_q   [DIV_STEPS][LANES];
	logic [MAG_W:0] trial [DIV_STEPS][LANES];
	logic     ge      [DIV_STEPS][LANES];
	mag_t     num_in  [LANES];

	always_comb begin
		num_in[LANE_T] = din.num_t;
		num_in[LANE_U] = din.num_u;
		num_in[LANE_V] = din.num_v;
		cur_den[0] = din.den;
		for (int l = 0; l < LANES; l++) begin
			// numerator is num * 2^16; its top bits seed the remainder
			cur_rem[0][l] = num_in[l] >> (QUO_W - FRAC_W);
			cur_nb[0][l]  = {num_in[l][QUO_W-FRAC_W-1:0], {FRAC_W{1'b0}}};
			cur_q[0][l]   = '0;
		end
		for (int k = 1; k < DIV_STEPS; k++) begin
			cur_den[k] = den_s[k];
			for (int l = 0; l < LANES; l++) begin
				cur_rem[k][l] = rem_s[k][l];
				cur_nb[k][l]  = nb_s[k][l];
				cur_q[k][l]   = q_s[k][l];
			end
		end
		for (int k = 0; k < DIV_STEPS; k++) begin
			for (int l = 0; l < LANES; l++) begin
				trial[k][l] = {cur_rem[k][l], cur_nb[k][l][QUO_W-1]};
				ge[k][l]    = (trial[k][l] >= {1'b0, cur_den[k]});
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 1; k <= DIV_STEPS; k++)
				valid_s[k] <= 1'b0;
		end else if (adv) begin
			valid_s[1] <= in_valid;
			for (int k = 2; k <= DIV_STEPS; k++)
				valid_s[k] <= valid_s[k-1];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			code_s[1] <= din.code;
			tsat_s[1] <= din.tsat;
			for (int k = 2; k <= DIV_STEPS; k++) begin
				code_s[k] <= code_s[k-1];
				tsat_s[k] <= tsat_s[k-1];
			end
			for (int k = 0; k < DIV_STEPS; k++) begin
				den_s[k+1] <= cur_den[k];
				for (int l = 0; l < LANES; l++) begin
					rem_s[k+1][l] <= ge[k][l] ? MAG_W'(trial[k][l] - {1'b0, cur_den[k]})
					                          : trial[k][l][MAG_W-1:0];
					nb_s[k+1][l]  <= cur_nb[k][l] << 1;
					q_s[k+1][l]   <= {cur_q[k][l][QUO_W-2:0], ge[k][l]};
				end
			end
		end
	end

	assign out_valid = valid_s[DIV_STEPS];
	assign dout.code = code_s[DIV_STEPS];
	assign dout.tsat = tsat_s[DIV_STEPS];
	assign dout.q_t  = q_s[DIV_STEPS][LANE_T];
	assign dout.q_u  = q_s[DIV_STEPS][LANE_U];
	assign dout.q_v  = q_s[DIV_STEPS][LANE_V];

endmodule

[src/ray_triangle_intersect.sv]
// Ray/triangle intersection unit, Moller-Trumbore test in exact fixed point.
// Input channel (in_valid/in_ready): req_type 0..2 loads vertex a, b or c from
// pos_x/y/z; req_type 3 tests a ray (origin pos_*, direction dir_*, Q8.8).
// A load takes effect at acceptance, so a ray accepted in the next cycle
// already sees it. Loads give no result; each ray gives exactly one.
// Output channel (out_valid/out_ready): hit, outcome, distance (Q16.16),
// bary_u and bary_v (Q1.16); distance and barycentrics are zero on a miss.
// Config channel (cfg_valid/cfg_ready, always ready): index 0 min_abs_det,
// index 1 min_t; other indexes are ignored. Write only while no ray is in flight.
// From acceptance to out_valid a ray passes 7 geometry stages, one
// stage per quotient bit of the 32-bit restoring divider, and the output register.
// Throughput is one item per cycle unless out_ready stalls; the divider pipeline sets the depth.
// When the receiver holds out_ready low with a result waiting, the whole pipeline
// freezes and in_ready drops in the same cycle; nothing is lost or repeated.
// Reset clears all valid bits, sets min_abs_det to 1 and min_t to 0, and zeroes
// the vertices, so every ray reports parallel until a triangle is loaded.
module ray_triangle_intersect (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [1:0]                        req_type,
	input  logic signed [15:0]                pos_x,
	input  logic signed [15:0]                pos_y,
	input  logic signed [15:0]                pos_z,
	input  logic signed [15:0]                dir_x,
	input  logic signed [15:0]                dir_y,
	input  logic signed [15:0]                dir_z,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [rti_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [rti_pkg::MIN_DET_W-1:0]     cfg_data,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic                              hit,
	output logic [2:0]                        outcome,
	output logic [31:0]                       distance,
	output logic [16:0]                       bary_u,
	output logic [16:0]                       bary_v
);
	import rti_pkg::*;

	logic [MIN_DET_W-1:0] min_abs_det_q;
	logic [MIN_T_W-1:0]   min_t_q;
	coord_t               vtx_q [9];

	vec3_t     va, vb, vc, org, dir;
	logic      adv, in_acc, ray_acc;
	logic      geom_valid, div_valid;
	div_in_t   geom_out;
	div_out_t  div_out;
	quo_t      dist_c;
	outcome_t  code_c;

	logic      out_valid_q, hit_q;
	outcome_t  outcome_q;
	quo_t      distance_q;
	logic [BARY_W-1:0] bary_u_q, bary_v_q;

	assign adv       = !(out_valid_q && !out_ready);
	assign in_ready  = adv;
	assign cfg_ready = 1'b1;
	assign in_acc    = in_valid && in_ready;
	assign ray_acc   = in_acc && (req_type == REQ_RAY);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_abs_det_q <= MIN_DET_W'(1);
			min_t_q       <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_MIN_ABS_DET: min_abs_det_q <= cfg_data;
				CFG_MIN_T:       min_t_q       <= cfg_data[MIN_T_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 9; i++)
				vtx_q[i] <= '0;
		end else if (in_acc) begin
			case (req_type)
				REQ_LOAD_A: begin
					vtx_q[0] <= pos_x;
					vtx_q[1] <= pos_y;
					vtx_q[2] <= pos_z;
				end
				REQ_LOAD_B: begin
					vtx_q[3] <= pos_x;
					vtx_q[4] <= pos_y;
					vtx_q[5] <= pos_z;
				end
				REQ_LOAD_C: begin
					vtx_q[6] <= pos_x;
					vtx_q[7] <= pos_y;
					vtx_q[8] <= pos_z;
				end
				default: ;
			endcase
		end
	end

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			va[i] = vtx_q[i];
			vb[i] = vtx_q[3+i];
			vc[i] = vtx_q[6+i];
		end
		org[0] = pos_x;
		org[1] = pos_y;
		org[2] = pos_z;
		dir[0] = dir_x;
		dir[1] = dir_y;
		dir[2] = dir_z;
	end

	rti_geom u_geom (
		.clk         (clk),
		.arst_n      (arst_n),
		.adv         (adv),
		.ray_valid   (ray_acc),
		.va          (va),
		.vb          (vb),
		.vc          (vc),
		.org         (org),
		.dir         (dir),
		.min_abs_det (min_abs_det_q),
		.out_valid   (geom_valid),
		.dout        (geom_out)
	);

	rti_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.in_valid  (geom_valid),
		.din       (geom_out),
		.out_valid (div_valid),
		.dout      (div_out)
	);

	always_comb begin
		dist_c = div_out.tsat ? '1 : div_out.q_t;
		code_c = div_out.code;
		if (code_c == OUT_HIT && dist_c <= QUO_W'(min_t_q))
			code_c = OUT_SHORT;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (adv)
			out_valid_q <= div_valid;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			hit_q     <= (code_c == OUT_HIT);
			outcome_q <= code_c;
			if (code_c == OUT_HIT) begin
				distance_q <= dist_c;
				bary_u_q   <= div_out.q_u[BARY_W-1:0];
				bary_v_q   <= div_out.q_v[BARY_W-1:0];
			end else begin
				distance_q <= '0;
				bary_u_q   <= '0;
				bary_v_q   <= '0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign hit       = hit_q;
	assign outcome   = outcome_q;
	assign distance  = distance_q;
	assign bary_u    = bary_u_q;
	assign bary_v    = bary_v_q;

	a_hit_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (hit == (outcome == OUT_HIT)))
		else $error("hit flag and outcome disagree");

	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !hit) |-> (distance == '0 && bary_u == '0 && bary_v == '0))
		else $error("miss result carries nonzero fields");

	a_bary_sum: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && hit) |-> ((BARY_W+1)'(bary_u) + (BARY_W+1)'(bary_v)
		                        <= (BARY_W+1)'(1 << FRAC_W)))
		else $error("barycentrics sum above one");

	a_hit_dist: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && hit) |-> (distance > QUO_W'(min_t_q)))
		else $error("hit at distance not above min_t");

endmodule
